// File: hdl/alp_pkg.sv
// ---------------------------------------------------------------------------
// alp_pkg
// Shared types, codes and helpers for the address lease pool.
// ---------------------------------------------------------------------------
package alp_pkg;

	localparam int POOL_ENTRIES = 256;
	localparam int CNT_W        = $clog2(POOL_ENTRIES + 1);

	localparam logic [1:0] OP_DISCOVER = 2'd0;
	localparam logic [1:0] OP_REQUEST  = 2'd1;
	localparam logic [1:0] OP_RELEASE  = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NOFREE   = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;
	localparam logic [1:0] ST_RENEWED  = 2'd3;

	localparam logic [1:0] REG_NETWORK = 2'd0;
	localparam logic [1:0] REG_PREFIX  = 2'd1;
	localparam logic [1:0] REG_GATEWAY = 2'd2;
	localparam logic [1:0] REG_LEASE   = 2'd3;

	localparam logic [31:0] NETWORK_RST = 32'hC0A8_0000;
	localparam logic [4:0]  PREFIX_RST  = 5'd24;
	localparam logic [31:0] GATEWAY_RST = 32'hC0A8_0001;
	localparam logic [31:0] LEASE_RST   = 32'd3600;

	typedef struct packed {
		logic        free;
		logic [47:0] owner;
		logic [31:0] expiry;
	} entry_t;

	typedef struct packed {
		logic        active;
		logic [1:0]  op;
		logic [47:0] mac;
		logic [31:0] now;
		logic [31:0] bind_exp;
		logic [31:0] lease;
		logic [31:0] addr;
		logic [31:0] cmp_addr;
		logic [31:0] gateway;
		logic        server_zero;
	} head_ctl_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] status;
	} head_res_t;

	function automatic logic [31:0] pool_base(input logic [31:0] net, input logic [4:0] p);
		logic [5:0]  sh;
		logic [63:0] mask;
		sh   = 6'd32 - {1'b0, p};
		mask = 64'hFFFF_FFFF << sh;
		return net & mask[31:0];
	endfunction

	function automatic logic [CNT_W-1:0] pool_size(input logic [4:0] p);
		logic [5:0]  sh;
		logic [63:0] hosts;
		sh    = 6'd32 - {1'b0, p};
		hosts = (64'd1 << sh) - 64'd2;
		if (hosts > 64'(POOL_ENTRIES)) begin
			return CNT_W'(POOL_ENTRIES);
		end
		return hosts[CNT_W-1:0];
	endfunction

endpackage

// File: hdl/address_lease_pool.sv
// ---------------------------------------------------------------------------
// address_lease_pool
// Address lease table held in a rotating ring of entry cells.
// ---------------------------------------------------------------------------
//  channel  | handshake           | payload
//  cfg      | cfg_we              | cfg_index, cfg_data
//  in       | in_valid / in_ready | opcode, client_mac, your_ip, client_ip,
//           |                     | server_ip, now_time
//  out      | out_valid/out_ready | result_ip, status
//
// Each request is taken while idle, then the ring rotates once through the
// single decision head, one entry per cycle, and the result is loaded into
// the output slot on the last rotation step if that slot is free.
// A new request is taken while an earlier result still waits at the output.
// Reset loads every cell at once; no clearing pass follows reset.
// A stalled output holds the finished result inside until the slot frees.
// ---------------------------------------------------------------------------
module address_lease_pool (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [47:0] client_mac,
	input  logic [31:0] your_ip,
	input  logic [31:0] client_ip,
	input  logic [31:0] server_ip,
	input  logic [31:0] now_time,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_ip,
	output logic [1:0]  status
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;

	logic [1:0]  state_q;
	logic [31:0] network_q;
	logic [4:0]  prefix_q;
	logic [31:0] gateway_q;
	logic [31:0] lease_q;

	logic [alp_pkg::CNT_W-1:0] cnt_q;
	logic [alp_pkg::CNT_W-1:0] size_q;
	logic        done_q;
	logic [1:0]  op_q;
	logic [47:0] mac_q;
	logic [31:0] now_q;
	logic [31:0] bind_exp_q;
	logic [31:0] addr_q;
	logic [31:0] cmp_addr_q;
	logic        server_zero_q;
	logic [31:0] rip_q;
	logic [1:0]  stat_q;

	logic        out_valid_q;
	logic [31:0] result_ip_q;
	logic [1:0]  status_q;

	logic               accept;
	logic               scan;
	logic               last;
	logic               slot_free;
	alp_pkg::head_ctl_t ctl;
	alp_pkg::head_res_t res;
	alp_pkg::entry_t    head_nxt;
	alp_pkg::entry_t    ring [alp_pkg::POOL_ENTRIES];

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign scan      = (state_q == S_SCAN);
	assign last      = (cnt_q == alp_pkg::CNT_W'(alp_pkg::POOL_ENTRIES - 1));
	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			network_q <= alp_pkg::NETWORK_RST;
			prefix_q  <= alp_pkg::PREFIX_RST;
			gateway_q <= alp_pkg::GATEWAY_RST;
			lease_q   <= alp_pkg::LEASE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				alp_pkg::REG_NETWORK: network_q <= cfg_data;
				alp_pkg::REG_PREFIX:  prefix_q  <= cfg_data[4:0];
				alp_pkg::REG_GATEWAY: gateway_q <= cfg_data;
				alp_pkg::REG_LEASE:   lease_q   <= cfg_data;
			endcase
		end
	end

	// capture the request and set up the scan
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q          <= opcode;
			mac_q         <= client_mac;
			now_q         <= now_time;
			bind_exp_q    <= now_time + lease_q;
			addr_q        <= alp_pkg::pool_base(network_q, prefix_q) + 32'd1;
			size_q        <= alp_pkg::pool_size(prefix_q);
			cmp_addr_q    <= (opcode == alp_pkg::OP_RELEASE) ? client_ip :
			                 ((your_ip != 32'd0) ? your_ip : client_ip);
			server_zero_q <= (server_ip == 32'd0);
			rip_q         <= '0;
			stat_q        <= (opcode == alp_pkg::OP_DISCOVER) ? alp_pkg::ST_NOFREE :
			                 alp_pkg::ST_NOTFOUND;
		end else if (scan) begin
			addr_q <= addr_q + 32'd1;
			if (res.hit) begin
				stat_q <= res.status;
				rip_q  <= (op_q == alp_pkg::OP_DISCOVER) ? addr_q : 32'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						done_q  <= 1'b0;
					end
				end
				S_SCAN: begin
					if (res.hit) begin
						done_q <= 1'b1;
					end
					if (last) begin
						cnt_q   <= '0;
						state_q <= slot_free ? S_IDLE : S_WAIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_WAIT: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (((scan && last) || (state_q == S_WAIT)) && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (scan && last && slot_free) begin
			result_ip_q <= res.hit ? ((op_q == alp_pkg::OP_DISCOVER) ? addr_q : 32'd0) : rip_q;
			status_q    <= res.hit ? res.status : stat_q;
		end else if ((state_q == S_WAIT) && slot_free) begin
			result_ip_q <= rip_q;
			status_q    <= stat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result_ip = result_ip_q;
	assign status    = status_q;

	always_comb begin
		ctl.active      = scan && !done_q && (cnt_q < size_q);
		ctl.op          = op_q;
		ctl.mac         = mac_q;
		ctl.now         = now_q;
		ctl.bind_exp    = bind_exp_q;
		ctl.lease       = lease_q;
		ctl.addr        = addr_q;
		ctl.cmp_addr    = cmp_addr_q;
		ctl.gateway     = gateway_q;
		ctl.server_zero = server_zero_q;
	end

	alp_head u_head (
		.ent     (ring[0]),
		.ctl     (ctl),
		.ent_nxt (head_nxt),
		.res     (res)
	);

	for (genvar i = 0; i < alp_pkg::POOL_ENTRIES; i++) begin : g_ring
		if (i == alp_pkg::POOL_ENTRIES - 1) begin : g_tail
			alp_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (scan),
				.d      (head_nxt),
				.q      (ring[i])
			);
		end else begin : g_body
			alp_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.shift  (scan),
				.d      (ring[i+1]),
				.q      (ring[i])
			);
		end
	end

`ifndef SYNTH
	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (cnt_q == '0))
		else $error("scan counter not at zero while idle");

	a_hit_done: assert property (@(posedge clk) disable iff (!arst_n)
		(scan && res.hit && !last) |=> done_q)
		else $error("hit in scan not recorded");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(scan && done_q) |-> !res.hit)
		else $error("second entry matched in one scan");

	a_disc_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE && op_q == alp_pkg::OP_DISCOVER) |-> (stat_q != alp_pkg::ST_RENEWED))
		else $error("discover reported renewal");
`endif

endmodule

// File: hdl/alp_cell.sv
// ---------------------------------------------------------------------------
// alp_cell
// One lease entry of the rotating ring; takes its neighbor's entry (the head's result at the tail) on shift.
// ---------------------------------------------------------------------------
module alp_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  alp_pkg::entry_t d,
	output alp_pkg::entry_t q
);

	alp_pkg::entry_t entry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q.free   <= 1'b1;
			entry_q.owner  <= '0;
			entry_q.expiry <= '0;
		end else if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule

// File: hdl/alp_head.sv
// ---------------------------------------------------------------------------
// alp_head
// Lease decision for the entry at the head of the ring in the current step.
// ---------------------------------------------------------------------------
module alp_head (
	input  alp_pkg::entry_t   ent,
	input  alp_pkg::head_ctl_t ctl,
	output alp_pkg::entry_t   ent_nxt,
	output alp_pkg::head_res_t res
);

	logic live;

	assign live = !ent.free && (ctl.now < ent.expiry) && (ent.owner == ctl.mac);

	always_comb begin
		ent_nxt    = ent;
		res.hit    = 1'b0;
		res.status = alp_pkg::ST_OK;
		if (ctl.active) begin
			unique case (ctl.op)
				alp_pkg::OP_DISCOVER: begin
					if (ctl.addr != ctl.gateway) begin
						if (live) begin
							res.hit = 1'b1;
						end else if (ent.free || (ctl.now >= ent.expiry)) begin
							ent_nxt.free = 1'b0;
							res.hit      = 1'b1;
						end
					end
				end
				alp_pkg::OP_REQUEST: begin
					if (ctl.addr == ctl.cmp_addr) begin
						res.hit = 1'b1;
						if (ctl.server_zero) begin
							ent_nxt.expiry = ent.expiry + ctl.lease;
							res.status     = alp_pkg::ST_RENEWED;
						end else if (!live) begin
							ent_nxt.owner  = ctl.mac;
							ent_nxt.expiry = ctl.bind_exp;
						end
					end
				end
				alp_pkg::OP_RELEASE: begin
					if ((ctl.addr == ctl.cmp_addr) && (ent.owner == ctl.mac)) begin
						ent_nxt.free   = 1'b1;
						ent_nxt.owner  = '0;
						ent_nxt.expiry = '0;
						res.hit        = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// File: dv/address_lease_pool_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// address_lease_pool_tb
// Self-checking bench for the address lease pool. A short table of directed
// requests runs at reset settings, then random phases under several subnet,
// gateway and lease settings. Typed rows are scored against their own reply,
// the rest by a predictor with its own lease table. Handshakes idle at random except in alternate phases.
// ---------------------------------------------------------------------------
module address_lease_pool_tb;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [47:0] mac;
		logic [31:0] yip;
		logic [31:0] cip;
		logic [31:0] sip;
		logic [31:0] now;
	} lease_req_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [1:0]  st;
	} lease_reply_t;

	typedef struct packed {
		lease_req_t   req;
		logic         typed;
		lease_reply_t reply;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  opcode;
	logic [47:0] client_mac;
	logic [31:0] your_ip;
	logic [31:0] client_ip;
	logic [31:0] server_ip;
	logic [31:0] now_time;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] result_ip;
	logic [1:0]  status;

	alp_pkg::entry_t lease_table [alp_pkg::POOL_ENTRIES];
	logic [31:0]  cur_network;
	logic [4:0]   cur_prefix;
	logic [31:0]  cur_gateway;
	logic [31:0]  cur_lease;
	lease_reply_t pending_replies [$];
	lease_reply_t oldest_reply;
	stim_row_t    stim_rows [$];
	int           mismatches = 0;
	bit           calm = 1'b0;
	logic [31:0]  clock_s = 32'd0;
	logic [47:0]  mac_set [6];

	address_lease_pool dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.client_mac (client_mac),
		.your_ip    (your_ip),
		.client_ip  (client_ip),
		.server_ip  (server_ip),
		.now_time   (now_time),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.result_ip  (result_ip),
		.status     (status)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [31:0] host_base();
		logic [32:0] host_bits;
		host_bits = (33'h1 << (6'd32 - {1'b0, cur_prefix})) - 33'h1;
		return cur_network & ~host_bits[31:0];
	endfunction

	function automatic int host_count();
		logic [32:0] hosts;
		hosts = (33'h1 << (6'd32 - {1'b0, cur_prefix})) - 33'h2;
		return (hosts > 33'(alp_pkg::POOL_ENTRIES)) ? alp_pkg::POOL_ENTRIES : int'(hosts);
	endfunction

	function automatic lease_reply_t predict_lease(input lease_req_t r);
		lease_reply_t rep;
		logic [31:0]  base;
		logic [31:0]  addr;
		logic [31:0]  target;
		int           n;
		int           i;
		bit           done;
		base   = host_base();
		n      = host_count();
		rep.ip = '0;
		rep.st = alp_pkg::ST_NOTFOUND;
		done   = 1'b0;
		target = (r.yip != 32'd0) ? r.yip : r.cip;
		case (r.op)
			alp_pkg::OP_DISCOVER: begin
				rep.st = alp_pkg::ST_NOFREE;
				for (i = 0; i < n && !done; i++) begin
					addr = base + 32'(i) + 32'd1;
					if (addr != cur_gateway) begin
						if (!lease_table[i].free && r.now < lease_table[i].expiry &&
								lease_table[i].owner == r.mac) begin
							rep.ip = addr;
							rep.st = alp_pkg::ST_OK;
							done   = 1'b1;
						end else if (lease_table[i].free || r.now >= lease_table[i].expiry) begin
							lease_table[i].free = 1'b0;
							rep.ip = addr;
							rep.st = alp_pkg::ST_OK;
							done   = 1'b1;
						end
					end
				end
			end
			alp_pkg::OP_REQUEST: begin
				for (i = 0; i < n && !done; i++) begin
					if (base + 32'(i) + 32'd1 == target) begin
						done = 1'b1;
						if (r.sip == 32'd0) begin
							lease_table[i].expiry = lease_table[i].expiry + cur_lease;
							rep.st = alp_pkg::ST_RENEWED;
						end else begin
							if (!(!lease_table[i].free && r.now < lease_table[i].expiry &&
									lease_table[i].owner == r.mac)) begin
								lease_table[i].owner  = r.mac;
								lease_table[i].expiry = r.now + cur_lease;
							end
							rep.st = alp_pkg::ST_OK;
						end
					end
				end
			end
			alp_pkg::OP_RELEASE: begin
				for (i = 0; i < n && !done; i++) begin
					if (base + 32'(i) + 32'd1 == r.cip && lease_table[i].owner == r.mac) begin
						lease_table[i].free   = 1'b1;
						lease_table[i].owner  = '0;
						lease_table[i].expiry = '0;
						rep.st = alp_pkg::ST_OK;
						done   = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		return rep;
	endfunction

	function automatic int idle_len();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_now();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return $urandom;
		if (r < 7) return 32'd0;
		if (r < 9) return 32'hFFFF_FFFF;
		clock_s = clock_s + 32'($urandom_range(0, 400));
		return clock_s;
	endfunction

	function automatic lease_req_t random_req();
		lease_req_t  r;
		logic [31:0] base;
		logic [31:0] slot_addr;
		logic [47:0] slot_mac;
		int          n;
		int          idx;
		int          sel;
		base = host_base();
		n    = host_count();
		r.mac = 48'({$urandom, $urandom});
		r.yip = $urandom;
		r.cip = $urandom;
		r.sip = $urandom;
		r.now = pick_now();
		slot_mac = ($urandom_range(0, 99) < 15) ? 48'({$urandom, $urandom}) :
			mac_set[$urandom_range(0, 5)];
		sel = $urandom_range(0, 99);
		if (sel < 75) begin
			idx       = $urandom_range(0, n);
			slot_addr = base + 32'(idx) + 32'd1;
			if (idx < n && !lease_table[idx].free && $urandom_range(0, 99) < 70) begin
				slot_mac = lease_table[idx].owner;
			end
		end else if (sel < 85) begin
			slot_addr = cur_gateway;
		end else if (sel < 90) begin
			slot_addr = base;
		end else begin
			slot_addr = $urandom;
		end
		r.mac = slot_mac;
		sel = $urandom_range(0, 99);
		if (sel < 35) begin
			r.op = alp_pkg::OP_DISCOVER;
		end else if (sel < 72) begin
			r.op = alp_pkg::OP_REQUEST;
			if ($urandom_range(0, 99) < 25) begin
				r.yip = '0;
				r.cip = slot_addr;
			end else begin
				r.yip = slot_addr;
			end
			sel = $urandom_range(0, 99);
			if (sel < 25) begin
				r.sip = '0;
			end else if (sel < 80) begin
				r.sip = cur_gateway;
			end
		end else if (sel < 94) begin
			r.op  = alp_pkg::OP_RELEASE;
			r.cip = slot_addr;
		end else begin
			r.op = OP_UNUSED;
		end
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic send_lease_req(input lease_req_t r, input bit typed, input lease_reply_t want);
		lease_reply_t pred;
		int           gap;
		opcode     <= r.op;
		client_mac <= r.mac;
		your_ip    <= r.yip;
		client_ip  <= r.cip;
		server_ip  <= r.sip;
		now_time   <= r.now;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pred = predict_lease(r);
		pending_replies.push_back(typed ? want : pred);
		@(negedge clk);
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic add_row(input logic [1:0] op, input logic [47:0] mac, input logic [31:0] yip,
			input logic [31:0] cip, input logic [31:0] sip, input logic [31:0] now,
			input bit typed, input logic [31:0] ip, input logic [1:0] st);
		stim_row_t row;
		row.req      = '{op: op, mac: mac, yip: yip, cip: cip, sip: sip, now: now};
		row.typed    = typed;
		row.reply.ip = ip;
		row.reply.st = st;
		stim_rows.push_back(row);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_replies.size() != 0) @(negedge clk);
	endtask

	task automatic run_phase(input logic [31:0] net, input int pre, input logic [31:0] gw,
			input logic [31:0] lease, input int count);
		logic [31:0] pre_word;
		drain();
		pre_word = ($urandom & 32'hFFFF_FFE0) | 32'(pre);
		cfg_we    <= 1'b1;
		cfg_index <= alp_pkg::REG_NETWORK;
		cfg_data  <= net;
		@(negedge clk);
		cfg_index <= alp_pkg::REG_PREFIX;
		cfg_data  <= pre_word;
		@(negedge clk);
		cfg_index <= alp_pkg::REG_GATEWAY;
		cfg_data  <= gw;
		@(negedge clk);
		cfg_index <= alp_pkg::REG_LEASE;
		cfg_data  <= lease;
		@(negedge clk);
		cfg_we      <= 1'b0;
		cur_network = net;
		cur_prefix  = pre_word[4:0];
		cur_gateway = gw;
		cur_lease   = lease;
		calm        = ~calm;
		clock_s     = $urandom;
		repeat (count) send_lease_req(random_req(), 1'b0, '0);
	endtask

	initial begin
		int hold;
		out_ready = 1'b0;
		hold      = 0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else begin
				hold = idle_len();
				out_ready <= (hold == 0);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_replies.size() == 0) begin
				flag_mismatch($sformatf("unexpected result ip %h status %0d", result_ip, status));
			end else begin
				oldest_reply = pending_replies.pop_front();
				if (result_ip !== oldest_reply.ip) begin
					flag_mismatch($sformatf("result_ip %h, want %h", result_ip, oldest_reply.ip));
				end
				if (status !== oldest_reply.st) begin
					flag_mismatch($sformatf("status %0d, want %0d", status, oldest_reply.st));
				end
			end
		end
	end

	initial begin
		#25_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [31:0] rnd_net;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_index  = alp_pkg::REG_NETWORK;
		cfg_data   = '0;
		in_valid   = 1'b0;
		opcode     = alp_pkg::OP_DISCOVER;
		client_mac = '0;
		your_ip    = '0;
		client_ip  = '0;
		server_ip  = '0;
		now_time   = '0;
		cur_network = alp_pkg::NETWORK_RST;
		cur_prefix  = alp_pkg::PREFIX_RST;
		cur_gateway = alp_pkg::GATEWAY_RST;
		cur_lease   = alp_pkg::LEASE_RST;
		for (int i = 0; i < alp_pkg::POOL_ENTRIES; i++) begin
			lease_table[i] = '{free: 1'b1, owner: '0, expiry: '0};
		end
		mac_set = '{48'h0, 48'hFFFF_FFFF_FFFF, 48'h0200_0000_0001, 48'h0200_0000_0002,
			48'hA5A5_5A5A_A5A5, 48'h0000_0000_0001};

		add_row(alp_pkg::OP_DISCOVER, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 100,
			1'b1, 32'hC0A8_0002, alp_pkg::ST_OK);
		add_row(alp_pkg::OP_DISCOVER, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 100,
			1'b1, 32'hC0A8_0002, alp_pkg::ST_OK);
		add_row(alp_pkg::OP_REQUEST, 48'hFFFF_FFFF_FFFF, 32'hC0A8_0002, 0, 32'hC0A8_0001, 100,
			1'b1, 0, alp_pkg::ST_OK);
		add_row(alp_pkg::OP_DISCOVER, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 200,
			1'b1, 32'hC0A8_0002, alp_pkg::ST_OK);
		add_row(alp_pkg::OP_DISCOVER, 48'h0, 0, 0, 0, 200,
			1'b1, 32'hC0A8_0003, alp_pkg::ST_OK);
		add_row(alp_pkg::OP_REQUEST, 48'h0000_1111_2222, 0, 32'hC0A8_0002, 0, 300,
			1'b1, 0, alp_pkg::ST_RENEWED);
		add_row(alp_pkg::OP_REQUEST, 48'h0, 32'h0A00_0001, 0, 1, 300,
			1'b1, 0, alp_pkg::ST_NOTFOUND);
		add_row(alp_pkg::OP_REQUEST, 48'h1234_5678_9ABC, 32'hC0A8_0001, 0, 32'hFFFF_FFFF, 0,
			1'b1, 0, alp_pkg::ST_OK);
		add_row(alp_pkg::OP_RELEASE, 48'h1234_5678_9ABC, 0, 32'hC0A8_0001, 0, 0,
			1'b1, 0, alp_pkg::ST_OK);
		add_row(alp_pkg::OP_RELEASE, 48'h0, 0, 32'hC0A8_0002, 0, 0,
			1'b1, 0, alp_pkg::ST_NOTFOUND);
		add_row(alp_pkg::OP_RELEASE, 48'hFFFF_FFFF_FFFF, 0, 32'hC0A8_0002, 0, 0,
			1'b1, 0, alp_pkg::ST_OK);
		add_row(OP_UNUSED, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1'b1, 0, alp_pkg::ST_NOTFOUND);
		add_row(alp_pkg::OP_DISCOVER, 48'h0, 0, 0, 0, 32'hFFFF_FFFF,
			1'b1, 32'hC0A8_0002, alp_pkg::ST_OK);
		add_row(alp_pkg::OP_REQUEST, 48'h0, 32'hFFFF_FFFF, 0, 5, 0,
			1'b1, 0, alp_pkg::ST_NOTFOUND);
		add_row(alp_pkg::OP_REQUEST, 48'h0, 0, 0, 5, 0,
			1'b1, 0, alp_pkg::ST_NOTFOUND);
		add_row(alp_pkg::OP_RELEASE, 48'h0, 0, 32'hFFFF_FFFF, 0, 0,
			1'b1, 0, alp_pkg::ST_NOTFOUND);
		add_row(alp_pkg::OP_REQUEST, 48'h1, 32'hC0A8_00FE, 0, 5, 32'hFFFF_FFFF,
			1'b1, 0, alp_pkg::ST_OK);
		add_row(alp_pkg::OP_REQUEST, 48'h1, 32'hC0A8_00FE, 0, 0, 0,
			1'b1, 0, alp_pkg::ST_RENEWED);
		add_row(alp_pkg::OP_REQUEST, 48'h1, 32'hC0A8_00FF, 0, 5, 0,
			1'b1, 0, alp_pkg::ST_NOTFOUND);
		add_row(alp_pkg::OP_DISCOVER, 48'h0, 0, 0, 0, 0,
			1'b0, 0, alp_pkg::ST_OK);
		add_row(alp_pkg::OP_REQUEST, 48'hFFFF_FFFF_FFFF, 32'hC0A8_0003, 0, 32'hFFFF_FFFF, 5000,
			1'b0, 0, alp_pkg::ST_OK);
		add_row(alp_pkg::OP_DISCOVER, 48'hFFFF_FFFF_FFFF, 0, 0, 0, 5001,
			1'b0, 0, alp_pkg::ST_OK);

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (stim_rows[k]) begin
			send_lease_req(stim_rows[k].req, stim_rows[k].typed, stim_rows[k].reply);
		end

		run_phase(32'hC0A8_0013, 30, 32'hC0A8_0011, 32'd5, 60);
		run_phase(32'hFFFF_FFFF, 29, 32'hFFFF_FFFA, 32'd0, 80);
		run_phase($urandom, 31, $urandom, $urandom, 25);
		run_phase(32'h0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 120);
		run_phase(32'h0A00_0000, 28, 32'h0A00_0005, 32'd100, 120);
		rnd_net = $urandom;
		run_phase(rnd_net, 24, {rnd_net[31:8], 8'($urandom_range(1, 254))},
			32'($urandom_range(1, 2000)), 150);
		run_phase($urandom, $urandom_range(0, 31), $urandom, $urandom, 100);
		run_phase(alp_pkg::NETWORK_RST, 24, alp_pkg::GATEWAY_RST, alp_pkg::LEASE_RST, 100);

		drain();
		repeat (300) @(negedge clk);
		if (mismatches == 0 && pending_replies.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/alp_pkg.sv
hdl/alp_cell.sv
hdl/alp_head.sv
hdl/address_lease_pool.sv
dv/address_lease_pool_tb.sv
